>>> src/avwe_pkg.sv
`default_nettype none

package avwe_pkg;

    localparam int CNT_IN_W  = 13;
    localparam int ULAW_W    = 8;
    localparam int NB_W      = 3;
    localparam int IDX_W     = 7;
    localparam int PRED_W    = 16;
    localparam int STEP_W    = 15;
    localparam int BYTE_W    = 8;
    localparam int S_DATA_W  = 24;

    localparam logic [NB_W-1:0]  NB_MIN     = 3'd2;
    localparam logic [NB_W-1:0]  NB_MAX     = 3'd6;
    localparam logic [IDX_W-1:0] IDX_LAST   = 7'd88;
    localparam logic [7:0]       ULAW_BIAS  = 8'h84;

    typedef enum logic
    {
        CMD_START  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_kind_t;

    // flag: empty packet on start, last sample on sample
    typedef struct packed
    {
        cmd_kind_t              kind;
        logic [NB_W-1:0]        nb;
        logic [2:0]             pad;
        logic                   flag;
        logic [ULAW_W-1:0]      ulaw;
    } cmd_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } fifo_status_t;

    localparam logic [STEP_W-1:0] STEP_TABLE [89] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,
        15'd12,    15'd13,    15'd14,    15'd16,    15'd17,
        15'd19,    15'd21,    15'd23,    15'd25,    15'd28,
        15'd31,    15'd34,    15'd37,    15'd41,    15'd45,
        15'd50,    15'd55,    15'd60,    15'd66,    15'd73,
        15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
        15'd337,   15'd371,   15'd408,   15'd449,   15'd494,
        15'd544,   15'd598,   15'd658,   15'd724,   15'd796,
        15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,
        15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,
        15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,
        15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
        15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
        15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

endpackage

`default_nettype wire

>>> src/avwe_front.sv
`default_nettype none

module avwe_front
    import avwe_pkg::*;
#(
    parameter int MAX_PACKET_SAMPLES = 4096
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [NB_W-1:0]      cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    input  wire logic                 s_tuser,
    input  wire fifo_status_t         q_status,
    output logic                      q_push,
    output cmd_t                      q_data
);

    localparam int CNT_FULL_W = $clog2(MAX_PACKET_SAMPLES + 1);
    localparam int CNT_W      = (CNT_FULL_W < CNT_IN_W) ? CNT_FULL_W : CNT_IN_W;

    logic [NB_W-1:0]   code_bits_reg;
    logic [NB_W-1:0]   packet_bits_reg;
    logic [CNT_W-1:0]  samples_left_reg;
    logic [CNT_W-1:0]  samples_left_next;
    logic [NB_W-1:0]   packet_bits_next;

    logic              accept;
    logic [CNT_IN_W-1:0] cnt_in;
    logic [CNT_W-1:0]  cnt_sat;
    logic [NB_W-1:0]   nb_clamped;
    logic [2:0]        pad_prod;
    logic [2:0]        pad;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_status.full;
    assign accept    = s_tvalid && s_tready;
    assign cnt_in    = s_tdata[CNT_IN_W-1:0];

    always_comb
    begin
        if (code_bits_reg < NB_MIN)
            nb_clamped = NB_MIN;
        else if (code_bits_reg > NB_MAX)
            nb_clamped = NB_MAX;
        else
            nb_clamped = code_bits_reg;

        if (32'(cnt_in) > 32'(MAX_PACKET_SAMPLES))
            cnt_sat = CNT_W'(MAX_PACKET_SAMPLES);
        else
            cnt_sat = CNT_W'(cnt_in);

        pad_prod = 3'(cnt_sat) * nb_clamped;
        pad      = 3'(4'd8 - {1'b0, pad_prod});
    end

    always_comb
    begin
        q_push            = 1'b0;
        q_data.kind       = CMD_START;
        q_data.nb         = nb_clamped;
        q_data.pad        = pad;
        q_data.flag       = (cnt_sat == '0);
        q_data.ulaw       = s_tdata[CNT_IN_W +: ULAW_W];
        samples_left_next = samples_left_reg;
        packet_bits_next  = packet_bits_reg;
        if (accept)
        begin
            if (cmd_kind_t'(s_tuser) == CMD_START)
            begin
                q_push            = 1'b1;
                samples_left_next = cnt_sat;
                packet_bits_next  = nb_clamped;
            end
            else if (samples_left_reg != '0)
            begin
                q_push            = 1'b1;
                q_data.kind       = CMD_SAMPLE;
                q_data.nb         = packet_bits_reg;
                q_data.flag       = (samples_left_reg == CNT_W'(1));
                samples_left_next = samples_left_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_bits_reg    <= NB_MAX;
            packet_bits_reg  <= NB_MAX;
            samples_left_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                code_bits_reg <= cfg_data;
            packet_bits_reg  <= packet_bits_next;
            samples_left_reg <= samples_left_next;
        end
    end

endmodule

`default_nettype wire

>>> src/avwe_cmd_fifo.sv
`default_nettype none

module avwe_cmd_fifo
    import avwe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire cmd_t     push_data,
    input  wire logic     pop,
    output cmd_t          pop_data,
    output fifo_status_t  status
);

    cmd_t        entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_push;
    logic        do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

>>> src/avwe_back.sv
`default_nettype none

module avwe_back
    import avwe_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fifo_status_t       q_status,
    input  wire cmd_t               q_data,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [BYTE_W-1:0]       m_tdata,
    output logic                    m_tlast
);

    typedef enum logic [2:0]
    {
        ST_IDLE  = 3'b001,
        ST_QUANT = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t                    state_reg, state_next;

    logic signed [PRED_W-1:0]  pred_reg, pred_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [BYTE_W-1:0]         buf_reg, buf_next;
    logic [2:0]                fill_reg, fill_next;

    // sample held between the expand and quantize steps
    logic [16:0]               diff_reg, diff_next;
    logic                      sign_reg, sign_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [NB_W-1:0]           nb_reg, nb_next;
    logic                      last_reg, last_next;

    logic [BYTE_W-1:0]         emit_byte_reg [4];
    logic [BYTE_W-1:0]         emit_byte_next [4];
    logic [3:0]                emit_last_reg, emit_last_next;
    logic [1:0]                emit_top_reg, emit_top_next;
    logic [1:0]                emit_idx_reg, emit_idx_next;

    logic                      out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]         out_byte_reg, out_byte_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_free;

    // expand stage
    logic [7:0]                uinv;
    logic [7:0]                ubase;
    logic [15:0]               umag;
    logic signed [16:0]        uval;
    logic signed [17:0]        udiff;

    // quantize stage
    logic [16:0]               rem;
    logic [STEP_W-1:0]         stp;
    logic [16:0]               vp;
    logic [4:0]                mag;
    logic [5:0]                delta;
    logic [5:0]                code;
    logic signed [17:0]        psum;
    logic signed [4:0]         adj;
    logic signed [7:0]         isum;
    logic [3:0]                total;
    logic [15:0]               place;
    logic [BYTE_W-1:0]         nbuf;
    logic [2:0]                nfill;
    logic                      have_byte;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign q_pop    = (state_reg == ST_IDLE) && !q_status.empty;

    always_comb
    begin
        uinv  = ~q_data.ulaw;
        ubase = {1'b0, uinv[3:0], 3'b000} + ULAW_BIAS;
        umag  = (16'(ubase) << uinv[6:4]) - 16'(ULAW_BIAS);
        uval  = uinv[7] ? -$signed({1'b0, umag}) : $signed({1'b0, umag});
        udiff = 18'(uval) - 18'(pred_reg);
    end

    always_comb
    begin
        rem = diff_reg;
        stp = step_reg;
        vp  = 17'(step_reg >> (nb_reg - 3'd1));
        mag = '0;
        for (int i = 0; i < 5; i++)
        begin
            if (3'(i) < nb_reg - 3'd1)
            begin
                if (rem >= {2'b00, stp})
                begin
                    mag[4-i] = 1'b1;
                    rem      = rem - {2'b00, stp};
                    vp       = vp + {2'b00, stp};
                end
                stp = stp >> 1;
            end
        end
        delta = {sign_reg, mag};
        code  = delta >> (3'd6 - nb_reg);

        if (sign_reg)
            psum = 18'(pred_reg) - $signed({1'b0, vp});
        else
            psum = 18'(pred_reg) + $signed({1'b0, vp});

        if (mag[4])
            adj = $signed({2'b00, mag[3:2], 1'b0}) + 5'sd2;
        else
            adj = -5'sd1;
        isum = $signed({1'b0, idx_reg}) + 8'(adj);

        total     = {1'b0, fill_reg} + {1'b0, nb_reg};
        place     = {buf_reg, 8'h00} | (16'(code) << (5'd16 - {1'b0, total}));
        have_byte = (total >= 4'd8);
        if (have_byte)
        begin
            nbuf  = place[7:0];
            nfill = 3'(total - 4'd8);
        end
        else
        begin
            nbuf  = place[15:8];
            nfill = total[2:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pred_next      = pred_reg;
        idx_next       = idx_reg;
        buf_next       = buf_reg;
        fill_next      = fill_reg;
        diff_next      = diff_reg;
        sign_next      = sign_reg;
        step_next      = step_reg;
        nb_next        = nb_reg;
        last_next      = last_reg;
        emit_byte_next = emit_byte_reg;
        emit_last_next = emit_last_reg;
        emit_top_next  = emit_top_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    if (q_data.kind == CMD_START)
                    begin
                        emit_byte_next[0] = {1'b0, q_data.nb, 1'b0, q_data.pad};
                        emit_byte_next[1] = pred_reg[15:8];
                        emit_byte_next[2] = pred_reg[7:0];
                        emit_byte_next[3] = {1'b0, idx_reg};
                        emit_last_next    = {q_data.flag, 3'b000};
                        emit_top_next     = 2'd3;
                        emit_idx_next     = 2'd0;
                        buf_next          = '0;
                        fill_next         = '0;
                        state_next        = ST_EMIT;
                    end
                    else
                    begin
                        sign_next  = udiff[17];
                        diff_next  = udiff[17] ? 17'(-udiff) : 17'(udiff);
                        step_next  = STEP_TABLE[idx_reg];
                        nb_next    = q_data.nb;
                        last_next  = q_data.flag;
                        state_next = ST_QUANT;
                    end
                end
            end

            ST_QUANT:
            begin
                if (psum > 18'sd32767)
                    pred_next = 16'sh7FFF;
                else if (psum < -18'sd32768)
                    pred_next = 16'sh8000;
                else
                    pred_next = psum[15:0];

                if (isum < 8'sd0)
                    idx_next = '0;
                else if (isum > $signed({1'b0, IDX_LAST}))
                    idx_next = IDX_LAST;
                else
                    idx_next = isum[IDX_W-1:0];

                emit_idx_next = 2'd0;
                emit_last_next = 4'b0000;
                buf_next       = nbuf;
                fill_next      = nfill;
                if (have_byte)
                begin
                    emit_byte_next[0] = place[15:8];
                    emit_last_next[0] = last_reg && (nfill == 3'd0);
                    emit_top_next     = 2'd0;
                    if (last_reg && nfill != 3'd0)
                    begin
                        emit_byte_next[1] = nbuf;
                        emit_last_next[1] = 1'b1;
                        emit_top_next     = 2'd1;
                    end
                end
                else
                begin
                    emit_byte_next[0] = nbuf;
                    emit_last_next[0] = 1'b1;
                    emit_top_next     = 2'd0;
                end

                if (last_reg && nfill != 3'd0)
                begin
                    buf_next  = '0;
                    fill_next = '0;
                end

                if (have_byte || (last_reg && nfill != 3'd0))
                    state_next = ST_EMIT;
                else
                    state_next = ST_IDLE;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = emit_byte_reg[emit_idx_reg];
                    out_last_next  = emit_last_reg[emit_idx_reg];
                    if (emit_idx_reg == emit_top_reg)
                        state_next = ST_IDLE;
                    else
                        emit_idx_next = emit_idx_reg + 2'd1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        diff_reg      <= diff_next;
        sign_reg      <= sign_next;
        step_reg      <= step_next;
        nb_reg        <= nb_next;
        last_reg      <= last_next;
        emit_byte_reg <= emit_byte_next;
        emit_last_reg <= emit_last_next;
        emit_top_reg  <= emit_top_next;
        emit_idx_reg  <= emit_idx_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pred_reg      <= '0;
            idx_reg       <= '0;
            buf_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pred_reg      <= pred_next;
            idx_reg       <= idx_next;
            buf_reg       <= buf_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> src/adpcm_variable_width_encoder.sv
// A start request reaches the output through the command queue, the emit state and the
// output register; a sample request through the queue, the quantize state, the emit state
// and the output register. The back end takes no new command until idle again: a start
// emits its four header bytes, a sample its bytes (if any), through a single output register.
// A 2-entry command queue lets the input side run ahead of the back end.
// Reset (rst_n low, async): predictor, step index, packing and packet count clear; width 6.
`default_nettype none

module adpcm_variable_width_encoder
    import avwe_pkg::*;
#(
    parameter int MAX_PACKET_SAMPLES = 4096
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [NB_W-1:0]      cfg_data,     // code_bits
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,      // packet_samples[12:0], ulaw_sample[20:13]
    input  wire logic                 s_tuser,      // action
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [BYTE_W-1:0]         m_tdata,      // out_byte
    output logic                      m_tlast
);

    fifo_status_t q_status;
    logic         q_push;
    logic         q_pop;
    cmd_t         q_wdata;
    cmd_t         q_rdata;

    avwe_front #(
        .MAX_PACKET_SAMPLES(MAX_PACKET_SAMPLES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    avwe_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_wdata),
        .pop      (q_pop),
        .pop_data (q_rdata),
        .status   (q_status)
    );

    avwe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_status(q_status),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

`default_nettype wire

>>> src/avwe_checker.sv
`default_nettype none

module avwe_checker
    import avwe_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_ready,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [BYTE_W-1:0]    m_tdata,
    input  wire logic                 m_tlast
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output request dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("input ready fell with no request accepted");

endmodule

bind adpcm_variable_width_encoder avwe_checker u_avwe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_ready(cfg_ready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
